FILE: rtl/midi_channel_message_parser_top_assert.svh
// Assertion macros for the MIDI channel message parser
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_TOP_ASSERT_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted
`define MCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mcp assertion failed");
// Clocked check that also holds during reset
`define MCP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mcp assertion failed");
`else
`define MCP_ASSERT(lbl, prop)
`define MCP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/mcp_pkg.sv
// Shared types and constants for the MIDI channel message parser
package mcp_pkg;

  localparam logic [7:0] STATUS_BIT   = 8'h80;
  localparam logic [7:0] SYSTEM_BASE  = 8'hF0;
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_PRESSURE = 4'hD;

  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_PROGRAM  = 2'd2
  } event_kind_e;

  // Parser state: running status, held data count, first data byte
  typedef struct packed {
    logic [7:0] status_held;
    logic       data_count;
    logic [6:0] first_data;
  } parse_state_t;

  typedef struct packed {
    logic        emit;
    event_kind_e kind;
    logic [3:0]  chan;
    logic [6:0]  key;
    logic [6:0]  vel;
  } parse_result_t;

endpackage

FILE: rtl/mcp_step.sv
// One parser step: next state and optional event for one received byte
module mcp_step (
  input  logic                   enable_i,
  input  logic [7:0]             rx_byte_i,
  input  mcp_pkg::parse_state_t  state_i,
  output mcp_pkg::parse_state_t  state_o,
  output mcp_pkg::parse_result_t result_o
);
  import mcp_pkg::*;

  logic [3:0] cmd;
  logic [6:0] data;

  assign cmd  = state_i.status_held[7:4];
  assign data = rx_byte_i[6:0];

  always_comb begin
    state_o       = state_i;
    result_o      = '0;
    result_o.kind = KIND_NOTE_OFF;
    result_o.chan = state_i.status_held[3:0];
    result_o.key  = state_i.first_data;
    priority if (!enable_i) begin
      // dropped, state untouched
    end else if ((rx_byte_i & STATUS_BIT) != 8'h00) begin
      state_o.status_held = (rx_byte_i >= SYSTEM_BASE) ? 8'h00 : rx_byte_i;
      state_o.data_count  = 1'b0;
    end else if (state_i.status_held == 8'h00) begin
      // stray data byte
    end else if (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) begin
      state_o.data_count = 1'b0;
      if (cmd == CMD_PROGRAM) begin
        result_o.emit = 1'b1;
        result_o.kind = KIND_PROGRAM;
        result_o.key  = data;
      end
    end else if (!state_i.data_count) begin
      state_o.first_data = data;
      state_o.data_count = 1'b1;
    end else begin
      state_o.data_count = 1'b0;
      if (cmd == CMD_NOTE_OFF) begin
        result_o.emit = 1'b1;
      end else if (cmd == CMD_NOTE_ON) begin
        result_o.emit = 1'b1;
        if (data != 7'd0) begin
          result_o.kind = KIND_NOTE_ON;
          result_o.vel  = data;
        end
      end
    end
  end

endmodule

FILE: rtl/midi_channel_message_parser_top.sv
// Top level of the MIDI channel message parser with running status
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one received
//   MIDI byte per request. Output channel (out_valid_o / out_stall_i and the
//   event fields) gives note off, note on and program change events.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_parser_enable_i)
//   writes the enable; writing 1 also clears the running status. Write it
//   only while no request is in flight.
// Timing:
//   Byte is registered on acceptance in the input register, parsed once the
//   output register is free or being taken, and the event lands in the
//   output register, which drives out_valid_o. One byte per cycle sustained
//   while the output is not stalled, set by the single parse stage.
// Reset:
//   Asynchronous, active low. Parser disabled, no running status, both
//   pipeline registers empty.
// Back-pressure:
//   A stalled event is held in the output register; one further byte can
//   still be taken into the input register, after which in_stall_o rises.
`include "midi_channel_message_parser_top_assert.svh"

module midi_channel_message_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_parser_enable_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [3:0] midi_channel_o,
  output logic [6:0] key_or_program_o,
  output logic [6:0] note_velocity_o
);
  import mcp_pkg::*;

  logic          enable_q, enable_d;
  parse_state_t  state_q, state_d, state_step;
  parse_result_t result_step;
  logic          in_valid_q, in_valid_d;
  logic [7:0]    byte_q;
  logic          out_valid_q, out_valid_d;
  parse_result_t out_q;
  logic          advance;
  logic          parse_fire;
  logic          in_accept;
  logic          cfg_write;

  // Parse stage may move when the result register is free or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign parse_fire = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Config only lands with the input register empty
  assign cfg_ready_o = !in_valid_q;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  mcp_step u_step (
    .enable_i  (enable_q),
    .rx_byte_i (byte_q),
    .state_i   (state_q),
    .state_o   (state_step),
    .result_o  (result_step)
  );

  always_comb begin
    enable_d = enable_q;
    state_d  = state_q;
    if (parse_fire) begin
      state_d = state_step;
    end
    if (cfg_write) begin
      enable_d = cfg_parser_enable_i;
      if (cfg_parser_enable_i) begin
        state_d = '0;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = parse_fire && result_step.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      enable_q    <= enable_d;
      state_q     <= state_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= rx_byte_i;
    end
    if (parse_fire && result_step.emit) begin
      out_q <= result_step;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = out_q.kind;
  assign midi_channel_o   = out_q.chan;
  assign key_or_program_o = out_q.key;
  assign note_velocity_o  = out_q.vel;

  `MCP_ASSERT(a_stall_only_when_full, in_stall_o |-> (out_valid_q && out_stall_i))
  `MCP_ASSERT(a_vel_only_note_on,
    (out_valid_o && event_kind_o != KIND_NOTE_ON) |-> (note_velocity_o == 7'd0))
  `MCP_ASSERT(a_note_on_vel_nonzero,
    (out_valid_o && event_kind_o == KIND_NOTE_ON) |-> (note_velocity_o != 7'd0))
  `MCP_ASSERT(a_no_event_when_disabled, (!out_valid_q && !enable_q) |=> !out_valid_q)
  `MCP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!in_valid_q && !out_valid_q))

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the MIDI channel message parser top level
module tb;
  import mcp_pkg::*;

  // Channel commands that the package does not name: consumed, never reported
  localparam logic [3:0] CMD_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] CMD_CONTROL       = 4'hB;
  localparam logic [3:0] CMD_PITCH_BEND    = 4'hE;

  localparam logic [7:0] NO_STATUS = 8'h00;

  // Receiver back-pressure styles, each held for a random stretch
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_e;

  // One note or programme event as it should leave the block
  typedef struct {
    event_kind_e kind;
    logic [3:0]  chan;
    logic [6:0]  key;
    logic [6:0]  vel;
  } midi_event_t;

  logic       clk_i               = 1'b0;
  logic       rst_ni              = 1'b0;
  logic       cfg_valid_i         = 1'b0;
  logic       cfg_parser_enable_i = 1'b0;
  logic       in_valid_i          = 1'b0;
  logic [7:0] rx_byte_i           = 8'h00;
  logic       out_stall_i         = 1'b0;
  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] event_kind_o;
  logic [3:0] midi_channel_o;
  logic [6:0] key_or_program_o;
  logic [6:0] note_velocity_o;

  // Bytes waiting for the driver, and events the parser owes us
  logic [7:0]  bytes_to_send[$];
  midi_event_t events_due[$];

  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches     = 0;

  // Our own copy of the parser: enable, running status, first data byte
  logic       parser_on   = 1'b0;
  logic [7:0] held_status = NO_STATUS;
  logic       have_first  = 1'b0;
  logic [6:0] first_key   = 7'd0;

  // Sender burst shaping and receiver stall pattern
  int          burst_left = 0;
  int          gap_left   = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  midi_channel_message_parser_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_parser_enable_i(cfg_parser_enable_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .event_kind_o       (event_kind_o),
    .midi_channel_o     (midi_channel_o),
    .key_or_program_o   (key_or_program_o),
    .note_velocity_o    (note_velocity_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------
  // Prediction: feed one accepted byte through the running-status parser
  // and queue the event it completes, if any.
  // --------------------------------------------------------------------
  function automatic void parse_midi_byte(input logic [7:0] b);
    logic [3:0]  cmd;
    midi_event_t ev;
    if (!parser_on) return;               // disabled: dropped, state kept
    if (b[7]) begin
      // status byte; system range cancels running status
      held_status = (b >= SYSTEM_BASE) ? NO_STATUS : b;
      have_first  = 1'b0;
      return;
    end
    if (held_status == NO_STATUS) return;  // stray data byte
    cmd     = held_status[7:4];
    ev.chan = held_status[3:0];
    ev.vel  = 7'd0;
    if (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) begin
      // one-data-byte messages; only programme change is reported
      have_first = 1'b0;
      if (cmd == CMD_PROGRAM) begin
        ev.kind = KIND_PROGRAM;
        ev.key  = b[6:0];
        events_due.push_back(ev);
      end
      return;
    end
    if (!have_first) begin
      first_key  = b[6:0];
      have_first = 1'b1;
      return;
    end
    have_first = 1'b0;
    ev.key     = first_key;
    // note on with zero velocity is a note off; note off drops its velocity
    if (cmd == CMD_NOTE_OFF || (cmd == CMD_NOTE_ON && b[6:0] == 7'd0)) begin
      ev.kind = KIND_NOTE_OFF;
      events_due.push_back(ev);
    end else if (cmd == CMD_NOTE_ON) begin
      ev.kind = KIND_NOTE_ON;
      ev.vel  = b[6:0];
      events_due.push_back(ev);
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    bytes_to_send.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void check_field(input string name, input logic [6:0] want,
                                      input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [6:0] random_data();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // --------------------------------------------------------------------
  // Random traffic: mostly well-formed messages under running status,
  // with some noise, system bytes and messages cut short.
  // --------------------------------------------------------------------
  task automatic queue_song(input int unsigned target);
    int unsigned start;
    int          msgs;
    logic [3:0]  cmd;
    logic [6:0]  vel;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      case ($urandom_range(0, 24))
        0, 1: queue_byte(8'($urandom_range(0, 255)));   // line noise
        2: begin
          // system byte, then data that must be ignored
          queue_byte(SYSTEM_BASE | 8'($urandom_range(0, 15)));
          repeat ($urandom_range(0, 2)) queue_byte({1'b0, random_data()});
        end
        default: begin
          case ($urandom_range(0, 9))
            0, 1:       cmd = CMD_NOTE_OFF;
            2, 3, 4, 5: cmd = CMD_NOTE_ON;
            6, 7:       cmd = CMD_PROGRAM;
            8:          cmd = CMD_PRESSURE;
            default:
              case ($urandom_range(0, 2))
                0:       cmd = CMD_POLY_PRESSURE;
                1:       cmd = CMD_CONTROL;
                default: cmd = CMD_PITCH_BEND;
              endcase
          endcase
          queue_byte({cmd, 4'($urandom_range(0, 15))});
          msgs = $urandom_range(1, 6);
          for (int m = 0; m < msgs; m++) begin
            queue_byte({1'b0, random_data()});
            if (cmd != CMD_PROGRAM && cmd != CMD_PRESSURE) begin
              // now and then leave the message half done
              if ($urandom_range(0, 19) == 0) break;
              vel = ($urandom_range(0, 5) == 0) ? 7'd0 : random_data();
              queue_byte({1'b0, vel});
            end
          end
        end
      endcase
    end
  endtask

  // Wait until every queued byte is taken and every event seen, then wait
  // out the settle time given by the caller for bytes that produce nothing.
  task automatic wait_quiet(input int settle);
    while (bytes_accepted != bytes_queued || events_due.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Only called when idle; enable of 1 also clears the parser state
  task automatic write_enable(input logic en);
    @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_parser_enable_i <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    parser_on = en;
    if (en) begin
      held_status = NO_STATUS;
      have_first  = 1'b0;
      first_key   = 7'd0;
    end
  endtask

  // --------------------------------------------------------------------
  // Sender: takes bytes from the pending queue in bursts with gaps.
  // Payload and valid are held while stalled.
  // --------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_midi_byte(rx_byte_i);
        bytes_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= bytes_to_send.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // long stretch with no idling
            gap_left   = 0;
            burst_left = $urandom_range(20, 60);
          end else begin
            gap_left   = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: a style is picked for a random stretch
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_left % 5) < 2);
    endcase
  end

  // Checker: each accepted event against the oldest one predicted
  always @(posedge clk_i) begin : event_check
    midi_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (events_due.size() == 0) begin
        $error("unexpected event: kind %0d channel %0d key %0d velocity %0d",
               event_kind_o, midi_channel_o, key_or_program_o, note_velocity_o);
        mismatches++;
      end else begin
        want = events_due.pop_front();
        check_field("event_kind", 7'(want.kind), 7'(event_kind_o));
        check_field("midi_channel", 7'(want.chan), 7'(midi_channel_o));
        check_field("key_or_program", want.key, key_or_program_o);
        check_field("note_velocity", want.vel, note_velocity_o);
      end
    end
  end

  // --------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the parser is disabled: these requests are dropped
    queue_byte({CMD_NOTE_ON, 4'h0});
    queue_byte(8'h3C);
    queue_byte(8'h7F);
    queue_byte({CMD_PROGRAM, 4'h1});
    queue_byte(8'h05);
    wait_quiet(4);
    write_enable(1'b1);

    // Directed messages
    queue_byte({CMD_NOTE_ON, 4'h0});      // note on, full velocity
    queue_byte(8'h3C);
    queue_byte(8'h7F);
    queue_byte(8'h00);                    // running status, velocity zero
    queue_byte(8'h00);
    queue_byte({CMD_NOTE_ON, 4'hF});      // top channel and key
    queue_byte(8'h7F);
    queue_byte(8'h01);
    queue_byte({CMD_NOTE_OFF, 4'h5});     // release velocity is discarded
    queue_byte(8'h40);
    queue_byte(8'h55);
    queue_byte({CMD_PROGRAM, 4'hA});      // two programmes, running status
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_byte({CMD_PRESSURE, 4'h3});     // consumed without an event
    queue_byte(8'h12);
    queue_byte({CMD_CONTROL, 4'h6});
    queue_byte(8'h07);
    queue_byte(8'h64);
    queue_byte(SYSTEM_BASE | 8'h0F);      // system byte kills running status
    queue_byte(8'h10);
    queue_byte({CMD_NOTE_ON, 4'h1});      // new status half way through
    queue_byte(8'h30);
    queue_byte({CMD_NOTE_ON, 4'h2});
    queue_byte(8'h31);
    queue_byte(8'h40);
    wait_quiet(4);

    // Re-enabling mid-message clears the state: the data that follows is stray
    queue_byte({CMD_NOTE_ON, 4'h3});
    queue_byte(8'h20);
    wait_quiet(4);
    write_enable(1'b1);
    queue_byte(8'h21);
    queue_byte(8'h22);
    queue_byte({CMD_PROGRAM, 4'h0});
    queue_byte(8'h11);
    wait_quiet(4);

    // Disabled while traffic flows: nothing comes out
    write_enable(1'b0);
    queue_song(40);
    wait_quiet(4);
    write_enable(1'b1);

    // Main random traffic; sometimes the sender stops until all is drained
    for (int chunk = 0; chunk < 10; chunk++) begin
      queue_song(140);
      if (chunk == 4) begin
        wait_quiet(4);
        write_enable(1'b0);
        queue_song(30);
        wait_quiet(4);
        write_enable(1'b1);
      end else if ($urandom_range(0, 2) == 0) begin
        wait_quiet(0);
      end else begin
        while (bytes_to_send.size() > 8) @(posedge clk_i);
      end
    end

    wait_quiet(8);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: midi_channel_message_parser_top.f
+incdir+rtl
rtl/mcp_pkg.sv
rtl/mcp_step.sv
rtl/midi_channel_message_parser_top.sv
sim/tb.sv
